// ===== rtl/core/plf_pkg.sv =====
package plf_pkg;

  localparam int LETTERS = 26;
  localparam int CELLS   = 25;
  localparam int SIDE    = 5;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_X = 5'd23;
  localparam letter_t LETTER_Z = 5'd25;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_KEY   = 2'd1,
    MODE_FILL  = 2'd2,
    MODE_PAIR  = 2'd3
  } mode_t;

  // requests from the sequencer to the square storage
  typedef struct packed {
    logic    clear;
    logic    place_en;
    letter_t place_ltr;
    letter_t place_rd;
    cell_t   cell_rd;
  } sq_cmd_t;

  typedef struct packed {
    cell_t   place;
    letter_t cell_ltr;
  } sq_stat_t;

  typedef struct packed {
    logic    valid;
    letter_t first;
    letter_t second;
  } res_t;

  // out of range reads as z, j reads as i
  function automatic letter_t plain_letter(letter_t v);
    letter_t l;
    l = (v > LETTER_Z) ? LETTER_Z : v;
    if (l == LETTER_J) l = LETTER_I;
    return l;
  endfunction

  function automatic cell_t cell_of(coord_t row, coord_t col);
    cell_t r;
    r = {2'b00, row};
    return cell_t'((r << 2) + r + {2'b00, col});
  endfunction

  function automatic coord_t cell_row(cell_t p);
    coord_t r;
    if (p >= cell_t'(4 * SIDE))      r = 3'd4;
    else if (p >= cell_t'(3 * SIDE)) r = 3'd3;
    else if (p >= cell_t'(2 * SIDE)) r = 3'd2;
    else if (p >= cell_t'(SIDE))     r = 3'd1;
    else                             r = 3'd0;
    return r;
  endfunction

  function automatic coord_t cell_col(cell_t p);
    cell_t d;
    d = p - cell_of(cell_row(p), 3'd0);
    return d[2:0];
  endfunction

  function automatic coord_t coord_inc(coord_t c);
    return (c == coord_t'(SIDE - 1)) ? 3'd0 : coord_t'(c + 3'd1);
  endfunction

endpackage

// ===== rtl/core/plf_square.sv =====
module plf_square (
  input  logic               clk,
  input  logic               rst,
  input  plf_pkg::sq_cmd_t   cmd,
  output plf_pkg::sq_stat_t  stat
);

  // only j is marked used after a clear
  localparam logic [plf_pkg::LETTERS-1:0] USED_AT_CLEAR =
    {{(plf_pkg::LETTERS-1){1'b0}}, 1'b1} << plf_pkg::LETTER_J;

  plf_pkg::letter_t                square_cell [plf_pkg::CELLS];
  plf_pkg::cell_t                  letter_place [plf_pkg::LETTERS];
  logic [plf_pkg::LETTERS-1:0]     letter_used;
  plf_pkg::cell_t                  fill_count;
  logic                            place_ok;

  always_comb begin
    place_ok = 1'b0;
    if (cmd.place_en && cmd.place_ltr <= plf_pkg::LETTER_Z &&
        fill_count < plf_pkg::cell_t'(plf_pkg::CELLS)) begin
      place_ok = !letter_used[cmd.place_ltr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < plf_pkg::CELLS; i++) square_cell[i] <= '0;
      for (int i = 0; i < plf_pkg::LETTERS; i++) letter_place[i] <= '0;
      letter_used <= USED_AT_CLEAR;
      fill_count <= '0;
    end else if (place_ok) begin
      square_cell[fill_count]       <= cmd.place_ltr;
      letter_place[cmd.place_ltr]   <= fill_count;
      letter_used[cmd.place_ltr]    <= 1'b1;
      fill_count                    <= fill_count + 5'd1;
    end
  end

  // single read port per table, address chosen by the sequencer
  assign stat.place    = letter_place[cmd.place_rd];
  assign stat.cell_ltr = square_cell[cmd.cell_rd];

endmodule

// ===== rtl/core/plf_seq.sv =====
module plf_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [4:0]         letter_a,
  input  logic [4:0]         letter_b,
  input  logic               single,
  output plf_pkg::sq_cmd_t   cmd,
  input  plf_pkg::sq_stat_t  stat,
  output plf_pkg::res_t      res,
  input  logic               res_free
);

  typedef enum logic [2:0] {
    IDLE, FILL, LOOK_A, LOOK_B, CELL_1, CELL_2, DONE
  } state_t;

  state_t            state;
  plf_pkg::letter_t  fill_k;
  plf_pkg::letter_t  ltr_a, ltr_b;
  plf_pkg::cell_t    pa, pb;
  plf_pkg::letter_t  c1, c2;
  plf_pkg::cell_t    place_clamped;
  plf_pkg::coord_t   ra, ca, rb, cb;
  plf_pkg::cell_t    idx1, idx2;
  logic              accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  assign place_clamped = (stat.place >= plf_pkg::cell_t'(plf_pkg::CELLS)) ? '0 : stat.place;

  always_comb begin
    ra = plf_pkg::cell_row(pa);
    ca = plf_pkg::cell_col(pa);
    rb = plf_pkg::cell_row(pb);
    cb = plf_pkg::cell_col(pb);
    if (ra == rb) begin
      idx1 = plf_pkg::cell_of(ra, plf_pkg::coord_inc(ca));
      idx2 = plf_pkg::cell_of(rb, plf_pkg::coord_inc(cb));
    end else if (ca == cb) begin
      idx1 = plf_pkg::cell_of(plf_pkg::coord_inc(ra), ca);
      idx2 = plf_pkg::cell_of(plf_pkg::coord_inc(rb), cb);
    end else begin
      // rectangle corners
      idx1 = plf_pkg::cell_of(ra, cb);
      idx2 = plf_pkg::cell_of(rb, ca);
    end
  end

  always_comb begin
    cmd.clear     = accept && (plf_pkg::mode_t'(mode) == plf_pkg::MODE_CLEAR);
    cmd.place_en  = (accept && (plf_pkg::mode_t'(mode) == plf_pkg::MODE_KEY)) ||
                    (state == FILL);
    cmd.place_ltr = (state == FILL) ? fill_k : letter_a;
    cmd.place_rd  = (state == LOOK_B) ? ltr_b : ltr_a;
    cmd.cell_rd   = (state == CELL_2) ? idx2 : idx1;
  end

  assign res.valid  = (state == DONE);
  assign res.first  = c1;
  assign res.second = c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      fill_k <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            unique case (plf_pkg::mode_t'(mode))
              plf_pkg::MODE_CLEAR, plf_pkg::MODE_KEY: state <= IDLE;
              plf_pkg::MODE_FILL: begin
                fill_k <= '0;
                state  <= FILL;
              end
              plf_pkg::MODE_PAIR: begin
                ltr_a <= plf_pkg::plain_letter(letter_a);
                ltr_b <= single ? plf_pkg::LETTER_X : plf_pkg::plain_letter(letter_b);
                state <= LOOK_A;
              end
              default: state <= IDLE;
            endcase
          end
        end
        FILL: begin
          // one letter offered to the square per cycle, a through z
          if (fill_k == plf_pkg::LETTER_Z) state <= IDLE;
          else fill_k <= fill_k + 5'd1;
        end
        LOOK_A: begin
          pa    <= place_clamped;
          state <= LOOK_B;
        end
        LOOK_B: begin
          pb    <= place_clamped;
          state <= CELL_1;
        end
        CELL_1: begin
          c1    <= stat.cell_ltr;
          state <= CELL_2;
        end
        CELL_2: begin
          c2    <= stat.cell_ltr;
          state <= DONE;
        end
        DONE: begin
          if (res_free) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/playfair_digraph_encrypt_unit.sv =====
// channel  handshake           payload
// in       in_valid/in_ready   mode, letter_a, letter_b, single
// out      out_valid/out_ready cipher_first, cipher_second
//
// clear and key letter act as they are accepted, leaving the unit idle; finish fill offers
// 26 letters in turn to the square's single write port
// a pair makes four reads in turn, two through each table's single read port
// (placement, then cell), then hands off into the output register
// synchronous reset empties the square and marks j as used
// a finished pair waits in its state while the output register is still full
module playfair_digraph_encrypt_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [4:0] letter_a,
  input  logic [4:0] letter_b,
  input  logic       single,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] cipher_first,
  output logic [4:0] cipher_second
);

  plf_pkg::sq_cmd_t  cmd;
  plf_pkg::sq_stat_t stat;
  plf_pkg::res_t     res;
  logic              res_free;

  assign res_free = !out_valid || out_ready;

  plf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .letter_a (letter_a),
    .letter_b (letter_b),
    .single   (single),
    .cmd      (cmd),
    .stat     (stat),
    .res      (res),
    .res_free (res_free)
  );

  plf_square u_square (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_free) begin
      cipher_first  <= res.first;
      cipher_second <= res.second;
    end
  end

endmodule
